[hdl/csd_pkg.sv]
// Shared types, character codes and keyword table of the checksummed sentence decoder.
package csd_pkg;

    // Parser phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_PROGRESS = 2'd0;
    localparam logic [1:0] ST_BAD_BYTE = 2'd1;
    localparam logic [1:0] ST_ACCEPT   = 2'd2;
    localparam logic [1:0] ST_REJECT   = 2'd3;

    // Keyword kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_LAST = 3'd5;

    // Framing characters
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // Widths fixed by the sentence format and the result word
    localparam int PLEN_W   = 7;
    localparam int OUT_VALW = 16;
    localparam int NUM_KW   = 5;

    // Keyword table, entry k maps to kind k+1
    localparam logic [23:0] KW_TABLE [NUM_KW] = '{"CHA", "ACC", "REV", "SHO", "RES"};

    // One result word
    typedef struct packed {
        logic [1:0]          status;
        logic [2:0]          event_kind;
        logic [OUT_VALW-1:0] value_a;
        logic [OUT_VALW-1:0] value_b;
        logic [OUT_VALW-1:0] value_c;
    } t_result;

    // Returns the kind of a three-letter keyword, or KIND_NONE.
    function automatic logic [2:0] f_keyword(input logic [23:0] chars);
        logic [2:0] kind;
        kind = KIND_NONE;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (chars == KW_TABLE[k]) begin
                kind = 3'(k + 1);
            end
        end
        return kind;
    endfunction

    // True for the characters 0 through 9.
    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[hdl/checksummed_sentence_decoder.sv]
// Top level of the checksummed sentence decoder.
// The block takes one character per clock while o_stall is low and returns
// exactly one result word per character, registered in the output stage. Each
// character updates the parser registers from combinational next-state logic
// (a multiply by ten with saturation is the longest path) when it is taken.
// Results pass through an output register plus one skid entry, so a
// character is still taken while one finished word waits; o_stall rises only
// when both entries are full. Status 0 means a sentence is in progress, 1 a
// stray or bad character, 2 an accepted sentence (kind and values valid) and
// 3 a rejected sentence; kind and values read zero unless status is 2.
module checksummed_sentence_decoder
    import csd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 80,
    parameter int VALUE_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_byte_in,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [2:0]          o_event_kind,
    output logic [OUT_VALW-1:0] o_value_a,
    output logic [OUT_VALW-1:0] o_value_b,
    output logic [OUT_VALW-1:0] o_value_c
);

    localparam int SUM_W = VALUE_BITS + 4;

    // Parser state
    logic [1:0]            r_phase, n_phase;
    logic [7:0]            r_xor, n_xor;
    logic [PLEN_W-1:0]     r_plen, n_plen;
    logic [7:0]            r_tok [3];
    logic [7:0]            n_tok [3];
    logic [2:0]            r_tlen, n_tlen;
    logic [2:0]            r_fpos, n_fpos;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_lead, n_lead;
    logic [2:0]            r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_vals [3];
    logic [VALUE_BITS-1:0] n_vals [3];
    logic                  r_ferr, n_ferr;
    logic [7:0]            r_rchk, n_rchk;
    logic [1:0]            r_ccnt, n_ccnt;

    logic                  w_accept;
    logic                  w_full;
    logic                  w_dig, w_cap, w_hex;
    logic                  w_do_end, w_do_take;
    logic [2:0]            w_kw;
    logic                  w_lead_eff;
    logic [SUM_W-1:0]      w_sum;
    logic [VALUE_BITS-1:0] w_acc_sat;
    logic [3:0]            w_nibble;
    logic                  w_ok;
    t_result               w_res;
    t_result               w_out;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = w_full;

    // Character classes
    assign w_dig = f_is_digit(i_byte_in);
    assign w_cap = (i_byte_in >= CH_UPPER_A) && (i_byte_in <= CH_UPPER_Z);
    assign w_hex = (i_byte_in >= CH_UPPER_A) && (i_byte_in <= CH_UPPER_F);

    // Keyword lookup on a finished three-letter token
    assign w_kw = (r_tlen == 3'd3) ? f_keyword({r_tok[0], r_tok[1], r_tok[2]}) : KIND_NONE;

    // Leading digit run: a token's first character decides whether it starts one.
    assign w_lead_eff = (r_tlen == 3'd0) ? w_dig : r_lead;

    // Accumulator times ten plus the digit, saturated to the value width
    assign w_sum     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                     + SUM_W'(i_byte_in[3:0]);
    assign w_acc_sat = (|w_sum[SUM_W-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                    : w_sum[VALUE_BITS-1:0];

    // Hex digit value of a checksum character
    assign w_nibble = w_dig ? i_byte_in[3:0] : 4'(i_byte_in[3:0] + 4'd9);

    // Sentence verdict at the newline
    assign w_ok = (r_ccnt == 2'd2) && (r_rchk == r_xor) && (r_plen != '0)
               && !r_ferr && (r_kind != KIND_NONE);

    // Next state and result word for one character
    always_comb begin
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_plen    = r_plen;
        n_tok     = r_tok;
        n_tlen    = r_tlen;
        n_fpos    = r_fpos;
        n_acc     = r_acc;
        n_lead    = r_lead;
        n_kind    = r_kind;
        n_vals    = r_vals;
        n_ferr    = r_ferr;
        n_rchk    = r_rchk;
        n_ccnt    = r_ccnt;
        w_do_end  = 1'b0;
        w_do_take = 1'b0;
        w_res     = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte_in == CH_DOLLAR) begin
                    n_phase = PH_PAYLOAD;
                    n_xor   = '0;
                    n_plen  = '0;
                    n_tok   = '{default: '0};
                    n_tlen  = '0;
                    n_fpos  = '0;
                    n_acc   = '0;
                    n_lead  = 1'b0;
                    n_kind  = KIND_NONE;
                    n_vals  = '{default: '0};
                    n_ferr  = 1'b0;
                    n_rchk  = '0;
                    n_ccnt  = '0;
                end else begin
                    w_res.status = ST_BAD_BYTE;
                end
            end
            PH_PAYLOAD: begin
                if (w_dig || w_cap || (i_byte_in == CH_COMMA)) begin
                    if (r_plen >= PLEN_W'(MAX_PAYLOAD)) begin
                        n_ferr = 1'b1;
                    end else begin
                        n_plen    = r_plen + 1'b1;
                        n_xor     = r_xor ^ i_byte_in;
                        w_do_end  = (i_byte_in == CH_COMMA);
                        w_do_take = (i_byte_in != CH_COMMA);
                    end
                end else if (i_byte_in == CH_STAR) begin
                    w_do_end = 1'b1;
                    n_rchk   = '0;
                    n_ccnt   = '0;
                    n_phase  = PH_CHECK;
                end else begin
                    w_res.status = ST_BAD_BYTE;
                    n_phase      = PH_IDLE;
                end
            end
            PH_CHECK: begin
                if (w_dig || w_hex) begin
                    if (r_ccnt < 2'd2) begin
                        n_rchk = {r_rchk[3:0], w_nibble};
                    end
                    if (r_ccnt != 2'd3) begin
                        n_ccnt = r_ccnt + 1'b1;
                    end
                end else if (i_byte_in == CH_NEWLINE) begin
                    n_phase = PH_IDLE;
                    if (w_ok) begin
                        w_res.status     = ST_ACCEPT;
                        w_res.event_kind = r_kind;
                        w_res.value_a    = OUT_VALW'(r_vals[0]);
                        w_res.value_b    = OUT_VALW'(r_vals[1]);
                        w_res.value_c    = OUT_VALW'(r_vals[2]);
                    end else begin
                        w_res.status = ST_REJECT;
                    end
                end else begin
                    w_res.status = ST_BAD_BYTE;
                    n_phase      = PH_IDLE;
                end
            end
            default: begin
                w_res.status = ST_BAD_BYTE;
                n_phase      = PH_IDLE;
            end
        endcase

        // Close the current field at a comma or at the star.
        if (w_do_end && (r_tlen != 3'd0)) begin
            if (w_kw != KIND_NONE) begin
                n_kind = w_kw;
                n_fpos = 3'd1;
            end else if ((r_fpos >= 3'd1) && (r_fpos <= 3'd3) && f_is_digit(r_tok[0])) begin
                case (r_fpos)
                    3'd1:    n_vals[0] = r_acc;
                    3'd2:    n_vals[1] = r_acc;
                    default: n_vals[2] = r_acc;
                endcase
                n_fpos = r_fpos + 1'b1;
            end else begin
                n_ferr = 1'b1;
            end
            n_tlen = '0;
            n_tok  = '{default: '0};
            n_acc  = '0;
            n_lead = 1'b0;
        end

        // Add one character to the current field.
        if (w_do_take) begin
            case (r_tlen)
                3'd0:    n_tok[0] = i_byte_in;
                3'd1:    n_tok[1] = i_byte_in;
                3'd2:    n_tok[2] = i_byte_in;
                default: ;
            endcase
            n_lead = w_lead_eff && w_dig;
            if (w_lead_eff && w_dig) begin
                n_acc = w_acc_sat;
            end
            if (r_tlen < 3'd4) begin
                n_tlen = r_tlen + 1'b1;
            end
        end
    end

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    // Frame registers, cleared at each start of frame
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xor  <= n_xor;
            r_plen <= n_plen;
            r_tok  <= n_tok;
            r_tlen <= n_tlen;
            r_fpos <= n_fpos;
            r_acc  <= n_acc;
            r_lead <= n_lead;
            r_kind <= n_kind;
            r_vals <= n_vals;
            r_ferr <= n_ferr;
            r_rchk <= n_rchk;
            r_ccnt <= n_ccnt;
        end
    end

    // Result stage
    csd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_status     = w_out.status;
    assign o_event_kind = w_out.event_kind;
    assign o_value_a    = w_out.value_a;
    assign o_value_b    = w_out.value_b;
    assign o_value_c    = w_out.value_c;

endmodule

[hdl/csd_outbuf.sv]
// Output register with a skid entry for the result words of the decoder.
module csd_outbuf
    import csd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    w_free;

    // The output slot frees up when it is empty or its word is taken.
    assign w_free = !r_out_vld || !i_stall;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_free) begin
            r_out_vld  <= r_skid_vld || i_push;
            r_skid_vld <= 1'b0;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Data words
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

[hdl/csd_checker.sv]
// Port-level checks of the checksummed sentence decoder and their bind.
module csd_checker
    import csd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic [7:0]          i_byte_in,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_status,
    input logic [2:0]          o_event_kind,
    input logic [OUT_VALW-1:0] o_value_a,
    input logic [OUT_VALW-1:0] o_value_b,
    input logic [OUT_VALW-1:0] o_value_c
);

    // The output holds a valid word in the cycle after every taken character.
    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("no result word after a taken character");

    // The input side stalls only behind a stalled output word.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a stalled output word");

    // A stall means both result entries hold words.
    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word");

    // Kind and values are zero unless the sentence was accepted.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_ACCEPT)) |->
        ((o_event_kind == KIND_NONE) && (o_value_a == '0) && (o_value_b == '0)
         && (o_value_c == '0)))
        else $error("decoded fields set on a word that is not an accepted sentence");

    // An accepted sentence always carries a keyword.
    a_accept_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ACCEPT)) |->
        ((o_event_kind != KIND_NONE) && (o_event_kind <= KIND_LAST)))
        else $error("accepted sentence without a keyword");

endmodule

bind checksummed_sentence_decoder csd_checker u_csd_checker (.*);
